// File: rtl/dngh_pkg.sv
`default_nettype none

package dngh_pkg;

	// Field and register widths
	localparam int GAIN_W      = 32;
	localparam int LEVEL_W     = 26;
	localparam int HOLD_W      = 16;
	localparam int MASK_W      = 5;
	localparam int COUNT_WIDTH = 16;
	localparam int CMP_W       = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;

	// Gain scaling: scaled = gain / GAIN_DIV, compared as gain vs (level[+1])*GAIN_DIV
	localparam int GAIN_DIV = 100;
	localparam int THR_W    = 33;

	// Stream widths
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;
	localparam int RES_W      = 7;

	// Drive bit positions
	localparam int DRV_WHITE = 0;
	localparam int DRV_IR850 = 1;
	localparam int DRV_IR940 = 2;
	localparam int DRV_IRCUT = 3;
	localparam int DRV_COLOR = 4;

	localparam logic [MASK_W-1:0] DRV_NIGHT_ON = 5'b10111;
	localparam logic [MASK_W-1:0] DRV_DAY_ON   = 5'b01000;
	localparam logic [MASK_W-1:0] DRV_RESET    = 5'b01000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DETECT_ENABLE     = 3'd0,
		CFG_NIGHT_ENTER_LEVEL = 3'd1,
		CFG_NIGHT_LEAVE_LEVEL = 3'd2,
		CFG_HOLD_SAMPLES      = 3'd3,
		CFG_DRIVE_ENABLE_MASK = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic              enable;
		logic [THR_W-1:0]  enter_thr;  // (night_enter_level + 1) * GAIN_DIV
		logic [THR_W-1:0]  leave_thr;  // night_leave_level * GAIN_DIV
		logic [HOLD_W-1:0] hold;
		logic [MASK_W-1:0] mask;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/dngh_cfg.sv
`default_nettype none

module dngh_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [dngh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dngh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output dngh_pkg::cfg_t                        cfg
);
	import dngh_pkg::*;

	logic [THR_W-1:0] lvl_ext;
	logic [THR_W-1:0] enter_thr_d;
	logic [THR_W-1:0] leave_thr_d;
	cfg_t             cfg_q;

	// Fold the divide into the thresholds: gain/100 > E  <=>  gain >= (E+1)*100,
	// gain/100 < L  <=>  gain < L*100.
	assign lvl_ext     = THR_W'(cfg_wdata[LEVEL_W-1:0]);
	assign enter_thr_d = (lvl_ext + THR_W'(1)) * THR_W'(GAIN_DIV);
	assign leave_thr_d = lvl_ext * THR_W'(GAIN_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= 1'b0;
			cfg_q.enter_thr <= THR_W'(GAIN_DIV);
			cfg_q.leave_thr <= '0;
			cfg_q.hold      <= '0;
			cfg_q.mask      <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DETECT_ENABLE:     cfg_q.enable    <= cfg_wdata[0];
				CFG_NIGHT_ENTER_LEVEL: cfg_q.enter_thr <= enter_thr_d;
				CFG_NIGHT_LEAVE_LEVEL: cfg_q.leave_thr <= leave_thr_d;
				CFG_HOLD_SAMPLES:      cfg_q.hold      <= cfg_wdata[HOLD_W-1:0];
				CFG_DRIVE_ENABLE_MASK: cfg_q.mask      <= cfg_wdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/day_night_gain_hysteresis_top.sv
// An accepted request goes through the compare register, then the result register, before
// its result is presented on the master side; back-pressure can hold it in either.
// Throughput: one request per cycle while m_tready is high; mode/counter loop in stage 2.
// Back-pressure stalls the two stages; stage 1 still fills while the result register waits.
// Reset (arst_n low, asynchronous): day mode, counters zero, lights off, ircut in,
// configuration registers zero except enter_thr (GAIN_DIV), both stages empty.
`default_nettype none

module day_night_gain_hysteresis_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [dngh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dngh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// Slave side: one gain sample per request
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [dngh_pkg::IN_DATA_W-1:0]    s_tdata,   // [31:0] gain_sample, [32] sample_valid
	// Master side: one result per sample
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [dngh_pkg::OUT_DATA_W-1:0]        m_tdata    // [0] is_night, [1] mode_flipped,
	                                                          // [2] white_drive, [3] ir850_drive,
	                                                          // [4] ir940_drive, [5] ircut_drive,
	                                                          // [6] color_night_run
);
	import dngh_pkg::*;

	cfg_t cfg;

	dngh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg
	);

	// ------------------------------------------------------------------
	// Pipeline control: each stage advances when the one after it frees up.
	// ------------------------------------------------------------------
	logic v_s1, v_s2;
	logic adv_s1, adv_s2;

	assign adv_s2   = !v_s2 || m_tready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1;

	// ------------------------------------------------------------------
	// Stage 1: threshold compares on the raw gain, registered.
	// ------------------------------------------------------------------
	logic [THR_W-1:0] gain_ext;
	logic             above_d, below_d;
	logic             above_s1, below_s1, ok_s1;

	assign gain_ext = THR_W'(s_tdata[GAIN_W-1:0]);
	assign above_d  = gain_ext >= cfg.enter_thr;
	assign below_d  = gain_ext <  cfg.leave_thr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			above_s1 <= above_d;
			below_s1 <= below_d;
			ok_s1    <= s_tdata[GAIN_W];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: hysteresis state update and result register.
	// ------------------------------------------------------------------
	logic                   night_q;
	logic [COUNT_WIDTH-1:0] ncnt_q, dcnt_q;
	logic [MASK_W-1:0]      drive_q;

	logic                   night_d;
	logic [COUNT_WIDTH-1:0] ncnt_d, dcnt_d;
	logic [COUNT_WIDTH-1:0] ncnt_up, dcnt_up;
	logic [MASK_W-1:0]      drive_d;
	logic                   flip_d;
	logic [RES_W-1:0]       res_d;
	logic [RES_W-1:0]       res_s2;
	logic                   take;

	assign take = v_s1 && adv_s2;

	// Saturating increments
	assign ncnt_up = (&ncnt_q) ? ncnt_q : ncnt_q + COUNT_WIDTH'(1);
	assign dcnt_up = (&dcnt_q) ? dcnt_q : dcnt_q + COUNT_WIDTH'(1);

	always_comb begin
		night_d = night_q;
		ncnt_d  = ncnt_q;
		dcnt_d  = dcnt_q;
		drive_d = drive_q;
		flip_d  = 1'b0;
		if (cfg.enable && ok_s1) begin
			if (!night_q && above_s1) begin
				// Count toward night; flip once the hold count is met
				dcnt_d = '0;
				ncnt_d = ncnt_up;
				if (CMP_W'(ncnt_up) >= CMP_W'(cfg.hold)) begin
					night_d = 1'b1;
					ncnt_d  = '0;
					flip_d  = 1'b1;
					drive_d = (drive_q & ~cfg.mask) | (DRV_NIGHT_ON & cfg.mask);
				end
			end else if (night_q && below_s1) begin
				// Count toward day
				ncnt_d = '0;
				dcnt_d = dcnt_up;
				if (CMP_W'(dcnt_up) >= CMP_W'(cfg.hold)) begin
					night_d = 1'b0;
					dcnt_d  = '0;
					flip_d  = 1'b1;
					drive_d = (drive_q & ~cfg.mask) | (DRV_DAY_ON & cfg.mask);
				end
			end else begin
				// Sample breaks the run: drop both counts
				ncnt_d = '0;
				dcnt_d = '0;
			end
		end
		res_d = {drive_d[DRV_COLOR], drive_d[DRV_IRCUT], drive_d[DRV_IR940],
		         drive_d[DRV_IR850], drive_d[DRV_WHITE], flip_d, night_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			night_q <= 1'b0;
			ncnt_q  <= '0;
			dcnt_q  <= '0;
			drive_q <= DRV_RESET;
			v_s2    <= 1'b0;
		end else begin
			if (take) begin
				night_q <= night_d;
				ncnt_q  <= ncnt_d;
				dcnt_q  <= dcnt_d;
				drive_q <= drive_d;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = OUT_DATA_W'(res_s2);

endmodule

`default_nettype wire

// File: verif/day_night_gain_hysteresis_top_tb.sv
`default_nettype none

module day_night_gain_hysteresis_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dngh_pkg::*;

	// Largest level the detector is specified for (2^32 - 1 divided by 100)
	localparam logic [LEVEL_W-1:0] MAX_LEVEL = 26'd42949672;
	localparam logic [31:0]        MAX_GAIN  = 32'hFFFF_FFFF;

	// Drive patterns a flip applies, bit0 white .. bit4 color
	localparam logic [MASK_W-1:0] LIGHTS_NIGHT  = 5'b10111;
	localparam logic [MASK_W-1:0] LIGHTS_DAY    = 5'b01000;
	localparam logic [MASK_W-1:0] LIGHTS_AT_RST = 5'b01000;

	// One result as it sits in m_tdata[6:0]; first member is the top bit
	typedef struct packed {
		logic color;
		logic ircut;
		logic ir940;
		logic ir850;
		logic white;
		logic flipped;
		logic night;
	} mode_result_t;

	// Tracks the detector state and holds the results still owed by the block
	class mode_tracker;
		logic                detect_on;
		logic [LEVEL_W-1:0]  enter_lvl;
		logic [LEVEL_W-1:0]  leave_lvl;
		logic [HOLD_W-1:0]   hold;
		logic [MASK_W-1:0]   mask;
		logic                night;
		logic [COUNT_WIDTH-1:0] to_night;
		logic [COUNT_WIDTH-1:0] to_day;
		logic [MASK_W-1:0]   lights;
		mode_result_t        expected_modes[$];
		int unsigned         errors;

		function new();
			detect_on = 1'b0;
			enter_lvl = '0;
			leave_lvl = '0;
			hold      = '0;
			mask      = '0;
			night     = 1'b0;
			to_night  = '0;
			to_day    = '0;
			lights    = LIGHTS_AT_RST;
			errors    = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_DETECT_ENABLE:     detect_on = value[0];
				CFG_NIGHT_ENTER_LEVEL: enter_lvl = value[LEVEL_W-1:0];
				CFG_NIGHT_LEAVE_LEVEL: leave_lvl = value[LEVEL_W-1:0];
				CFG_HOLD_SAMPLES:      hold      = value[HOLD_W-1:0];
				CFG_DRIVE_ENABLE_MASK: mask      = value[MASK_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the detector by one accepted sample and queue its result
		function void take_sample(logic [GAIN_W-1:0] gain, logic valid);
			logic [GAIN_W-1:0] scaled;
			mode_result_t      res;
			logic              flipped;
			flipped = 1'b0;
			if (detect_on && valid) begin
				scaled = gain / 32'd100;
				if (!night && scaled > GAIN_W'(enter_lvl)) begin
					to_night = (to_night == '1) ? to_night : to_night + 1'b1;
					to_day   = '0;
					if (CMP_W'(to_night) >= CMP_W'(hold)) begin
						night    = 1'b1;
						lights   = (lights & ~mask) | (LIGHTS_NIGHT & mask);
						to_night = '0;
						flipped  = 1'b1;
					end
				end else if (night && scaled < GAIN_W'(leave_lvl)) begin
					to_day   = (to_day == '1) ? to_day : to_day + 1'b1;
					to_night = '0;
					if (CMP_W'(to_day) >= CMP_W'(hold)) begin
						night   = 1'b0;
						lights  = (lights & ~mask) | (LIGHTS_DAY & mask);
						to_day  = '0;
						flipped = 1'b1;
					end
				end else begin
					to_night = '0;
					to_day   = '0;
				end
			end
			res.night   = night;
			res.flipped = flipped;
			res.white   = lights[0];
			res.ir850   = lights[1];
			res.ir940   = lights[2];
			res.ircut   = lights[3];
			res.color   = lights[4];
			expected_modes.push_back(res);
		endfunction

		function void match_result(logic [OUT_DATA_W-1:0] data);
			mode_result_t got;
			mode_result_t want;
			got = mode_result_t'(data[RES_W-1:0]);
			if (expected_modes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result %b with nothing outstanding", $realtime, got);
				return;
			end
			want = expected_modes.pop_front();
			if (got.night !== want.night || got.flipped !== want.flipped ||
			    got.white !== want.white || got.ir850 !== want.ir850 ||
			    got.ir940 !== want.ir940 || got.ircut !== want.ircut ||
			    got.color !== want.color) begin
				errors++;
				if (errors <= 10)
					$display("%0t: night/flip/white/850/940/cut/color exp %b%b %b%b%b%b%b got %b%b %b%b%b%b%b",
						$realtime, want.night, want.flipped, want.white, want.ir850,
						want.ir940, want.ircut, want.color, got.night, got.flipped,
						got.white, got.ir850, got.ir940, got.ircut, got.color);
			end
		endfunction

		function int waiting();
			return expected_modes.size();
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;

	mode_tracker tracker = new();

	int          burst_left   = 0;
	int unsigned active_items = 0;
	int unsigned rx_cycle     = 0;
	int          rx_stall     = 0;

	day_night_gain_hysteresis_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [31:0] gain_sample, [32] sample_valid
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)    // [0] is_night, [1] mode_flipped, [2] white, [3] ir850,
		                        // [4] ir940, [5] ircut, [6] color_night_run
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop: a hung handshake or a lost result lands here
	initial begin
		#16_000_000;
		$display("day_night_gain_hysteresis_top_tb: done, errors");
		$finish;
	end

	// Result side: check every accepted result, then pick the next ready level.
	// The stall pattern rotates through four modes: always ready, coin flip,
	// three of four, and random bursts of stalls.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_result(m_tdata);
		rx_cycle++;
		case ((rx_cycle / 256) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (rx_cycle % 4) != 3;
			default: begin
				if (rx_stall > 0) begin
					rx_stall--;
					m_tready <= 1'b0;
				end else if ($urandom_range(0, 9) == 0) begin
					rx_stall = $urandom_range(0, 7);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	// Gain whose scaled value is above lvl, or all ones if none exists
	function automatic logic [31:0] gain_above(input logic [LEVEL_W-1:0] lvl);
		longint unsigned lo;
		lo = (longint'(lvl) + 1) * 100;
		if (lo > 64'(MAX_GAIN))
			return MAX_GAIN;
		case ($urandom_range(0, 3))
			0: return lo[31:0];
			1: return (lo + 300 > 64'(MAX_GAIN)) ? MAX_GAIN : lo[31:0] + $urandom_range(0, 300);
			2: return $urandom_range(lo[31:0], MAX_GAIN);
			default: return MAX_GAIN;
		endcase
	endfunction

	// Gain whose scaled value is below lvl, or zero if none exists
	function automatic logic [31:0] gain_below(input logic [LEVEL_W-1:0] lvl);
		logic [31:0] hi;
		if (lvl == '0)
			return '0;
		hi = 32'(lvl) * 32'd100 - 32'd1;
		case ($urandom_range(0, 3))
			0: return hi;
			1: return (hi < 300) ? 32'd0 : hi - $urandom_range(0, 300);
			2: return $urandom_range(0, hi);
			default: return '0;
		endcase
	endfunction

	// Present one sample request and hold it until accepted. Bursts of random
	// length are separated by random gaps; now and then a long burst runs flat out.
	task automatic send_sample(input logic [31:0] gain, input logic valid);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 24);
		end
		burst_left--;
		s_tdata  <= {7'd0, valid, gain};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		active_items++;
		tracker.take_sample(gain, valid);
	endtask

	// Drop valid and wait until every outstanding result is back, then idle before returning
	task automatic drain();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (tracker.waiting() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		tracker.set_reg(idx, value);
	endtask

	// Write all five registers back to back; junk in the unused upper bits
	// must be ignored by the block.
	task automatic program_regs(input logic en, input logic [LEVEL_W-1:0] enter_lvl,
	                            input logic [LEVEL_W-1:0] leave_lvl,
	                            input logic [HOLD_W-1:0] hold, input logic [MASK_W-1:0] mask);
		write_reg(CFG_DETECT_ENABLE,     {25'($urandom), en});
		write_reg(CFG_NIGHT_ENTER_LEVEL, enter_lvl);
		write_reg(CFG_NIGHT_LEAVE_LEVEL, leave_lvl);
		write_reg(CFG_HOLD_SAMPLES,      {10'($urandom), hold});
		write_reg(CFG_DRIVE_ENABLE_MASK, {21'($urandom), mask});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A sample that counts toward leaving the current mode
	function automatic logic [31:0] qualifying_gain();
		return tracker.night ? gain_below(tracker.leave_lvl) : gain_above(tracker.enter_lvl);
	endfunction

	// A sample that counts toward the mode already held, so it clears the counters
	function automatic logic [31:0] opposing_gain();
		return tracker.night ? gain_above(tracker.enter_lvl) : gain_below(tracker.leave_lvl);
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MAX_LEVEL;
			2: return $urandom_range(0, MAX_LEVEL);
			default: return $urandom_range(0, 5000);
		endcase
	endfunction

	initial begin
		int phase_len;
		int run_len;
		int sent;
		int r;
		logic [HOLD_W-1:0] hold;
		logic [MASK_W-1:0] mask;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the detector is off: samples must leave all state alone
		send_sample(MAX_GAIN, 1'b1);
		send_sample(32'd0, 1'b1);
		drain();

		// Hold count zero: the first qualifying sample flips straight to night
		program_regs(1'b1, '0, '0, '0, 5'b11111);
		send_sample(32'd100, 1'b1);
		send_sample(32'd99, 1'b1);    // scaled 0 is not below a zero leave level
		send_sample(MAX_GAIN, 1'b0);  // failed read
		drain();

		// Levels at their maximum: full-scale gain sits exactly on the level
		program_regs(1'b1, MAX_LEVEL, MAX_LEVEL, '0, 5'b01001);
		send_sample(MAX_GAIN, 1'b1);
		send_sample(32'd4294967199, 1'b1);  // one step below the leave level
		send_sample(MAX_GAIN, 1'b1);
		drain();

		// Hold of two with a failed read inside the run and a neutral breaker
		program_regs(1'b1, 26'd5, 26'd3, 16'd2, 5'b10110);
		send_sample(32'd599, 1'b1);
		send_sample(32'd600, 1'b1);
		send_sample(32'd0, 1'b0);
		send_sample(32'd700, 1'b1);
		send_sample(32'd299, 1'b1);
		send_sample(32'd300, 1'b1);
		send_sample(32'd299, 1'b1);
		send_sample(32'd0, 1'b1);
		drain();

		// Disabled again: qualifying gain is frozen out
		program_regs(1'b0, '0, '0, '0, 5'b11111);
		send_sample(32'd600, 1'b1);
		drain();

		// Largest hold count: a short qualifying run keeps counting without a flip
		program_regs(1'b1, '0, MAX_LEVEL, 16'hFFFF, 5'($urandom));
		repeat (40) send_sample(qualifying_gain(), 1'b1);
		drain();

		// Random phases: fresh settings, then mostly qualifying runs near the
		// hold count, mixed with failed reads, counter clears and raw noise.
		active_items = 0;
		while (active_items < 1000) begin
			case ($urandom_range(0, 11))
				0:       hold = '0;
				1:       hold = $urandom_range(0, 40);
				2:       hold = 16'hFFFF;
				default: hold = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 3))
				0:       mask = '0;
				1:       mask = '1;
				default: mask = 5'($urandom);
			endcase
			program_regs($urandom_range(0, 9) != 0, pick_level(), pick_level(), hold, mask);

			phase_len = $urandom_range(30, 120);
			sent = 0;
			while (sent < phase_len) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					run_len = int'(tracker.hold) + $urandom_range(0, 2);
					if (run_len > 60)
						run_len = 60;
					for (int k = 0; k <= run_len; k++) begin
						case ($urandom_range(0, 19))
							0:       send_sample($urandom, 1'b0);
							1:       send_sample(opposing_gain(), 1'b1);
							default: send_sample(qualifying_gain(), 1'b1);
						endcase
					end
					sent += run_len + 1;
				end else if (r < 80) begin
					send_sample($urandom, 1'b0);
					sent++;
				end else if (r < 90) begin
					send_sample(opposing_gain(), 1'b1);
					sent++;
				end else begin
					send_sample($urandom, 1'($urandom_range(0, 1)));
					sent++;
				end
				// Hold off now and then until the block has answered everything
				if ($urandom_range(0, 49) == 0)
					drain();
			end
			drain();
		end

		drain();
		if (tracker.errors == 0 && tracker.waiting() == 0)
			$display("day_night_gain_hysteresis_top_tb: done, clean");
		else
			$display("day_night_gain_hysteresis_top_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
